// File: hdl/mf3_pkg.sv
// mf3_pkg: shared types, constants and helpers of the 3x3 median filter
// used by mf3_scan, mf3_median9 and median_filter_3x3; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mf3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int WIN_N     = 9;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  localparam int DIM_A = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
  localparam int DIM_W = (DIM_A > ROW_W + 1) ? DIM_A : ROW_W + 1;

  localparam int MIN_DIM = 3;
  localparam int BORDER  = 2;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = CFG_W'(1024);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH   = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic has_res;
    logic line_end;
    logic frame_end;
  } tag_t;

  typedef struct packed {
    logic valid;
    tag_t tag;
  } stage_t;

  // last position index for a configured dimension; the dimension is clamped to [MIN_DIM, hi] first
  function automatic logic [DIM_W-1:0] dim_last(input logic [CFG_W-1:0] v,
                                                input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] x;
    x = DIM_W'(v);
    if (x < DIM_W'(MIN_DIM)) begin
      x = DIM_W'(MIN_DIM);
    end else if (x > hi) begin
      x = hi;
    end
    return x - DIM_W'(1);
  endfunction

endpackage

`default_nettype wire

// File: hdl/median_filter_3x3.sv
// median_filter_3x3: top level, configuration registers and result register
// depends on mf3_pkg, mf3_scan and mf3_median9
//
// Usage:
//   Pixels enter in raster order on pixel_i with pixel_valid_i/pixel_ready_o.
//   A transfer happens when valid and ready are both high on a clock edge.
//   Results leave on median_o, line_end_o, frame_end_o with
//   result_valid_o/result_ready_i. Only pixels whose 3x3 window lies inside
//   the frame (column >= 2 and row >= 2) produce a result; border pixels
//   produce none.
//   cfg_we_i writes cfg_data_i to register cfg_index_i (0 line width,
//   1 frame height) on the same edge; write only while the pipe is empty.
//   A result is registered through the input stage, the window register and the result register.
//   Throughput: one pixel per cycle while the receiver keeps up; the line store is one read and one
//   write port memory, read at pixel transfer and written one stage later.
//   A stalled receiver holds the result register; pixels keep flowing until
//   the window and input stages fill, then pixel_ready_o drops.
//   Reset clears the counters, the pipe and restores width and height 1024;
//   the line store is not cleared and needs no initialisation.
`timescale 1ns / 1ps
`default_nettype none

module median_filter_3x3 (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [mf3_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [mf3_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire logic                             pixel_valid_i,
  output logic                                  pixel_ready_o,
  input  wire logic [mf3_pkg::PIX_W-1:0]        pixel_i,
  output logic                                  result_valid_o,
  input  wire logic                             result_ready_i,
  output logic [mf3_pkg::PIX_W-1:0]             median_o,
  output logic                                  line_end_o,
  output logic                                  frame_end_o
);

  logic [mf3_pkg::CFG_W-1:0] line_width_q;
  logic [mf3_pkg::CFG_W-1:0] frame_height_q;

  mf3_pkg::stage_t           win_stat;
  mf3_pkg::win_t             win;
  logic [mf3_pkg::PIX_W-1:0] median;

  logic                      out_free;
  logic                      out_load;
  logic                      win_take;

  logic                      result_valid_q;
  logic [mf3_pkg::PIX_W-1:0] median_q;
  logic                      line_end_q;
  logic                      frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= mf3_pkg::LINE_WIDTH_RST;
      frame_height_q <= mf3_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (mf3_pkg::cfg_reg_e'(cfg_index_i))
        mf3_pkg::REG_LINE_WIDTH:   line_width_q   <= cfg_data_i;
        mf3_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mf3_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .line_width_i   (line_width_q),
    .frame_height_i (frame_height_q),
    .pixel_valid_i  (pixel_valid_i),
    .pixel_ready_o  (pixel_ready_o),
    .pixel_i        (pixel_i),
    .win_take_i     (win_take),
    .win_stat_o     (win_stat),
    .win_o          (win)
  );

  mf3_median9 u_median (
    .win_i    (win),
    .median_o (median)
  );

  // window items without a result drain without touching the output
  assign out_free = !result_valid_q || result_ready_i;
  assign win_take = win_stat.valid && (!win_stat.tag.has_res || out_free);
  assign out_load = win_stat.valid && win_stat.tag.has_res && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else if (out_load) begin
      result_valid_q <= 1'b1;
    end else if (result_ready_i) begin
      result_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      median_q    <= median;
      line_end_q  <= win_stat.tag.line_end;
      frame_end_q <= win_stat.tag.frame_end;
    end
  end

  assign result_valid_o = result_valid_q;
  assign median_o       = median_q;
  assign line_end_o     = line_end_q;
  assign frame_end_o    = frame_end_q;

endmodule

`default_nettype wire

// File: hdl/mf3_ram.sv
// mf3_ram: generic simple dual-port RAM, one write and one registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/mf3_median9.sv
// mf3_median9: 19 compare-exchange network giving the median of nine pixels
// depends on mf3_pkg
`timescale 1ns / 1ps
`default_nettype none

module mf3_median9 (
  input  wire mf3_pkg::win_t                  win_i,
  output logic [mf3_pkg::PIX_W-1:0]           median_o
);

  // returns {min, max}
  function automatic logic [2*mf3_pkg::PIX_W-1:0] sort2(
    input logic [mf3_pkg::PIX_W-1:0] a,
    input logic [mf3_pkg::PIX_W-1:0] b
  );
    return (a < b) ? {a, b} : {b, a};
  endfunction

  logic [mf3_pkg::PIX_W-1:0] v [mf3_pkg::WIN_N];

  always_comb begin
    for (int i = 0; i < mf3_pkg::WIN_N; i++) begin
      v[i] = win_i[i];
    end
    {v[1], v[2]} = sort2(v[1], v[2]);
    {v[4], v[5]} = sort2(v[4], v[5]);
    {v[7], v[8]} = sort2(v[7], v[8]);
    {v[0], v[1]} = sort2(v[0], v[1]);
    {v[3], v[4]} = sort2(v[3], v[4]);
    {v[6], v[7]} = sort2(v[6], v[7]);
    {v[1], v[2]} = sort2(v[1], v[2]);
    {v[4], v[5]} = sort2(v[4], v[5]);
    {v[7], v[8]} = sort2(v[7], v[8]);
    {v[0], v[3]} = sort2(v[0], v[3]);
    {v[5], v[8]} = sort2(v[5], v[8]);
    {v[4], v[7]} = sort2(v[4], v[7]);
    {v[3], v[6]} = sort2(v[3], v[6]);
    {v[1], v[4]} = sort2(v[1], v[4]);
    {v[2], v[5]} = sort2(v[2], v[5]);
    {v[4], v[7]} = sort2(v[4], v[7]);
    {v[4], v[2]} = sort2(v[4], v[2]);
    {v[6], v[4]} = sort2(v[6], v[4]);
    {v[4], v[2]} = sort2(v[4], v[2]);
  end

  assign median_o = v[4];

endmodule

`default_nettype wire

// File: hdl/mf3_scan.sv
// mf3_scan: raster counters, one line store holding two lines and the 3x3 window register
// depends on mf3_pkg and mf3_ram
`timescale 1ns / 1ps
`default_nettype none

module mf3_scan (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [mf3_pkg::CFG_W-1:0]     line_width_i,
  input  wire logic [mf3_pkg::CFG_W-1:0]     frame_height_i,
  input  wire logic                          pixel_valid_i,
  output logic                               pixel_ready_o,
  input  wire logic [mf3_pkg::PIX_W-1:0]     pixel_i,
  input  wire logic                          win_take_i,
  output mf3_pkg::stage_t                    win_stat_o,
  output mf3_pkg::win_t                      win_o
);

  localparam int PW = mf3_pkg::PIX_W;
  localparam int CW = mf3_pkg::COL_W;
  localparam int RW = mf3_pkg::ROW_W;
  localparam int DW = mf3_pkg::DIM_W;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [DW-1:0] col_last_w, row_last_w;
  logic [CW-1:0] col_last, col_eff;
  logic [RW-1:0] row_last, row_eff;
  logic          last_col, last_row;
  mf3_pkg::tag_t tag_d;

  logic          in_xfer;
  logic          s1_adv;
  logic          s2_free;

  logic          s1_valid_q;
  logic [PW-1:0] s1_px_q;
  logic [CW-1:0] s1_addr_q;
  mf3_pkg::tag_t s1_tag_q;

  logic            fwd_hit_q;
  logic [2*PW-1:0] fwd_data_q;

  logic [2*PW-1:0] ram_rdata;
  logic [2*PW-1:0] line_rd;
  logic [2*PW-1:0] line_wr;
  logic [PW-1:0]   top_px, mid_px;

  mf3_pkg::stage_t s2_q;
  mf3_pkg::win_t   win_q;

  // position of the incoming pixel, clamped to the configured frame
  always_comb begin
    col_last_w = mf3_pkg::dim_last(line_width_i, DW'(mf3_pkg::MAX_WIDTH));
    row_last_w = mf3_pkg::dim_last(frame_height_i, DW'(mf3_pkg::MAX_HEIGHT));
    col_last   = col_last_w[CW-1:0];
    row_last   = row_last_w[RW-1:0];
    col_eff    = (col_q >= col_last) ? col_last : col_q;
    row_eff    = (row_q >= row_last) ? row_last : row_q;
    last_col   = (col_eff == col_last);
    last_row   = (row_eff == row_last);

    tag_d.has_res   = (col_eff >= CW'(mf3_pkg::BORDER)) && (row_eff >= RW'(mf3_pkg::BORDER));
    tag_d.line_end  = last_col;
    tag_d.frame_end = last_col && last_row;

    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_eff + RW'(1);
    end else begin
      col_d = col_eff + CW'(1);
      row_d = row_eff;
    end
  end

  assign s2_free       = !s2_q.valid || win_take_i;
  assign s1_adv        = s1_valid_q && s2_free;
  assign pixel_ready_o = !s1_valid_q || s2_free;
  assign in_xfer       = pixel_valid_i && pixel_ready_o;

  // line store word: upper line in the high byte, middle line in the low byte
  mf3_ram #(
    .WIDTH (2 * PW),
    .DEPTH (mf3_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_addr_q),
    .wdata_i (line_wr),
    .re_i    (in_xfer),
    .raddr_i (col_eff),
    .rdata_o (ram_rdata)
  );

  // write landing on the same edge as the read is bypassed
  assign line_rd = fwd_hit_q ? fwd_data_q : ram_rdata;
  assign top_px  = line_rd[2*PW-1:PW];
  assign mid_px  = line_rd[PW-1:0];
  assign line_wr = {mid_px, s1_px_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_tag_q   <= '0;
      fwd_hit_q  <= 1'b0;
      s2_q       <= '0;
      win_q      <= '0;
    end else begin
      if (in_xfer) begin
        col_q      <= col_d;
        row_q      <= row_d;
        s1_tag_q   <= tag_d;
        fwd_hit_q  <= s1_adv && (s1_addr_q == col_eff);
      end
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_q.valid <= 1'b1;
        s2_q.tag   <= s1_tag_q;
        win_q[0]   <= win_q[1];
        win_q[1]   <= win_q[2];
        win_q[2]   <= top_px;
        win_q[3]   <= win_q[4];
        win_q[4]   <= win_q[5];
        win_q[5]   <= mid_px;
        win_q[6]   <= win_q[7];
        win_q[7]   <= win_q[8];
        win_q[8]   <= s1_px_q;
      end else if (win_take_i) begin
        s2_q.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_px_q    <= pixel_i;
      s1_addr_q  <= col_eff;
      fwd_data_q <= line_wr;
    end
  end

  assign win_stat_o = s2_q;
  assign win_o      = win_q;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// tb_top: self-checking bench for median_filter_3x3, raster frames in, medians out
// keeps its own line history, window and counters to predict every median and flag
// depends on mf3_pkg and median_filter_3x3
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam int PW = mf3_pkg::PIX_W;
  localparam int CW = mf3_pkg::CFG_W;

  // compare-exchange pairs of the median network, index that takes the minimum in the upper nibble
  localparam logic [0:18][7:0] MEDIAN_NET = {
    8'h12, 8'h45, 8'h78, 8'h01, 8'h34, 8'h67, 8'h12, 8'h45, 8'h78, 8'h03,
    8'h58, 8'h47, 8'h36, 8'h14, 8'h25, 8'h47, 8'h42, 8'h64, 8'h42
  };

  typedef struct packed {
    logic [PW-1:0] median;
    logic          line_end;
    logic          frame_end;
  } median_res_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [CW-1:0]                 cfg_data_i;
  logic                          pixel_valid_i;
  logic                          pixel_ready_o;
  logic [PW-1:0]                 pixel_i;
  logic                          result_valid_o;
  logic                          result_ready_i;
  logic [PW-1:0]                 median_o;
  logic                          line_end_o;
  logic                          frame_end_o;

  // predicted filter state
  logic [CW-1:0] cfg_width;
  logic [CW-1:0] cfg_height;
  logic [PW-1:0] line_hist [0:2*mf3_pkg::MAX_WIDTH-1];
  logic [PW-1:0] window_px [0:8];
  int unsigned   col_cnt;
  int unsigned   row_cnt;
  median_res_t   median_q [$];

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_reqs;
  int unsigned hold_seen = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  median_filter_3x3 u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pixel_valid_i  (pixel_valid_i),
    .pixel_ready_o  (pixel_ready_o),
    .pixel_i        (pixel_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .median_o       (median_o),
    .line_end_o     (line_end_o),
    .frame_end_o    (frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_dim(input logic [CW-1:0] v, input int unsigned hi);
    if (v < mf3_pkg::MIN_DIM) return mf3_pkg::MIN_DIM;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  task automatic predict_median(input logic [PW-1:0] px);
    int unsigned   w;
    int unsigned   h;
    int unsigned   col;
    int unsigned   row;
    int unsigned   a;
    int unsigned   b;
    logic [PW-1:0] top;
    logic [PW-1:0] mid;
    logic [PW-1:0] lo;
    logic [PW-1:0] hi;
    logic [PW-1:0] v [0:8];
    logic          last_col;
    logic          last_row;
    median_res_t   r;
    w = clamp_dim(cfg_width, mf3_pkg::MAX_WIDTH);
    h = clamp_dim(cfg_height, mf3_pkg::MAX_HEIGHT);
    col = (col_cnt >= w - 1) ? w - 1 : col_cnt;
    row = (row_cnt >= h - 1) ? h - 1 : row_cnt;
    last_col = (col == w - 1);
    last_row = (row == h - 1);
    top = line_hist[col];
    mid = line_hist[mf3_pkg::MAX_WIDTH + col];
    line_hist[col] = mid;
    line_hist[mf3_pkg::MAX_WIDTH + col] = px;
    window_px[0] = window_px[1]; window_px[1] = window_px[2]; window_px[2] = top;
    window_px[3] = window_px[4]; window_px[4] = window_px[5]; window_px[5] = mid;
    window_px[6] = window_px[7]; window_px[7] = window_px[8]; window_px[8] = px;
    if (col >= 2 && row >= 2) begin
      v = window_px;
      for (int k = 0; k < 19; k++) begin
        a = 32'(MEDIAN_NET[k][7:4]);
        b = 32'(MEDIAN_NET[k][3:0]);
        lo = (v[a] < v[b]) ? v[a] : v[b];
        hi = (v[a] < v[b]) ? v[b] : v[a];
        v[a] = lo;
        v[b] = hi;
      end
      r.median = v[4];
      r.line_end = last_col;
      r.frame_end = last_col && last_row;
      median_q = {median_q, r};
    end
    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
      row_cnt = row;
    end
  endtask

  function automatic logic [PW-1:0] random_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return PW'($urandom_range(15));
      default: return PW'($urandom);
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_pixel(input logic [PW-1:0] px);
    while ($urandom_range(99) < idle_pct) begin
      pixel_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    pixel_valid_i <= 1'b1;
    pixel_i <= px;
    @(posedge clk_i);
    while (!pixel_ready_o) @(posedge clk_i);
    predict_median(px);
    @(negedge clk_i);
  endtask

  task automatic wait_results_done();
    pixel_valid_i <= 1'b0;
    while (median_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input mf3_pkg::cfg_reg_e idx, input logic [CW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == mf3_pkg::REG_LINE_WIDTH) cfg_width = val;
    else cfg_height = val;
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [CW-1:0] w, input logic [CW-1:0] h);
    wait_results_done();
    write_reg(mf3_pkg::REG_LINE_WIDTH, w);
    write_reg(mf3_pkg::REG_FRAME_HEIGHT, h);
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) send_pixel(random_pixel());
  endtask

  task automatic complete_frame();
    while (col_cnt != 0 || row_cnt != 0) send_pixel(random_pixel());
  endtask

  // reset geometry is 1024 x 1024: two lines and four pixels, then shrink to 3 x 3 past the column counter
  task automatic test_reset_geometry();
    send_random(2 * 1024 + 4);
    wait_results_done();
    write_reg(mf3_pkg::REG_LINE_WIDTH, 11'd3);
    write_reg(mf3_pkg::REG_FRAME_HEIGHT, 11'd3);
    complete_frame();
  endtask

  task automatic test_small_frames();
    logic [PW-1:0] px;
    configure(11'd3, 11'd3);
    for (int f = 0; f < 5; f++) begin
      for (int k = 0; k < 9; k++) begin
        case (f)
          0: px = '0;
          1: px = '1;
          2: px = (k % 2) ? 8'hff : 8'h00;
          3: px = PW'(k * 31);
          default: px = PW'(255 - k);
        endcase
        send_pixel(px);
      end
    end
    configure(11'd0, 11'd1);
    send_random(9);
    configure(11'd2, 11'd0);
    send_random(9);
    configure(11'd4, 11'd2);
    complete_frame();
    send_random(12);
  endtask

  // shrink width while past the new last column, then height while past the new last row
  task automatic test_midframe_shrink();
    configure(11'd8, 11'd8);
    send_random(2 * 8 + 6);
    wait_results_done();
    write_reg(mf3_pkg::REG_LINE_WIDTH, 11'd5);
    send_random(1 + 5);
    wait_results_done();
    write_reg(mf3_pkg::REG_FRAME_HEIGHT, 11'd3);
    complete_frame();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    configure(11'd6, 11'd6);
    hold_reqs = hold_reqs + 1;
    send_random(100);
    complete_frame();
    send_random(20);
    wait_results_done();
    complete_frame();
  endtask

  task automatic test_random_frames(input int unsigned send_idle, input int unsigned recv_stall,
                                    input int unsigned n_items);
    int unsigned   sent;
    logic [CW-1:0] w;
    logic [CW-1:0] h;
    idle_pct = send_idle;
    stall_pct = recv_stall;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(19))
        0: w = CW'($urandom_range(2));
        1: w = CW'($urandom_range(13, 64));
        default: w = CW'($urandom_range(3, 12));
      endcase
      h = ($urandom_range(9) == 0) ? CW'($urandom_range(2)) : CW'($urandom_range(3, 8));
      configure(w, h);
      repeat ($urandom_range(1, 3)) begin
        do begin
          send_pixel(random_pixel());
          sent++;
        end while (col_cnt != 0 || row_cnt != 0);
      end
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    result_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ready_i <= 1'b0;
      end else begin
        result_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    median_res_t want;
    if (rst_ni && result_valid_o && result_ready_i) begin
      if (median_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: median %0d line_end %0b frame_end %0b",
                   median_o, line_end_o, frame_end_o);
      end else begin
        want = median_q.pop_front();
        if (median_o !== want.median || line_end_o !== want.line_end ||
            frame_end_o !== want.frame_end) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: median %0d/%0d line_end %0b/%0b frame_end %0b/%0b (exp/got)",
                     want.median, median_o, want.line_end, line_end_o,
                     want.frame_end, frame_end_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((pixel_valid_i && pixel_ready_o) || (result_valid_o && result_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    pixel_valid_i = 1'b0;
    pixel_i = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_reqs = 0;
    cfg_width = mf3_pkg::LINE_WIDTH_RST;
    cfg_height = mf3_pkg::FRAME_HEIGHT_RST;
    col_cnt = 0;
    row_cnt = 0;
    for (int k = 0; k < 9; k++) window_px[k] = '0;
    for (int k = 0; k < 2 * mf3_pkg::MAX_WIDTH; k++) line_hist[k] = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_geometry();
    test_small_frames();
    test_midframe_shrink();
    test_backpressure();
    test_random_frames(0, 0, 60);
    test_random_frames(82, 0, 60);
    test_random_frames(0, 82, 60);
    test_random_frames(28, 28, 60);

    wait_results_done();
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/mf3_pkg.sv
hdl/mf3_ram.sv
hdl/mf3_median9.sv
hdl/mf3_scan.sv
hdl/median_filter_3x3.sv
tb/tb_top.sv
